### src/ipa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ipa_pkg;

   // Map geometry
   localparam int POOL_ENTRIES = 4096;
   localparam int WORD_W       = 32;
   localparam int BIT_W        = $clog2(WORD_W);
   localparam int MAP_WORDS    = (POOL_ENTRIES + WORD_W - 1) / WORD_W;
   localparam int WIDX_W       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int OFF_W        = WIDX_W + BIT_W;

   // Field widths
   localparam int POS_W     = 32;
   localparam int PFXH_W    = 64;
   localparam int CSR_W     = 64;
   localparam int CSR_IDX_W = 3;
   localparam int STATUS_W  = 3;
   localparam int REQ_W     = 2;

   // Request kinds
   localparam logic [REQ_W-1:0] REQ_STATIC  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_DYNAMIC = 2'd1;
   localparam logic [REQ_W-1:0] REQ_RECLAIM = 2'd2;
   localparam logic [REQ_W-1:0] REQ_VERIFY  = 2'd3;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_IN_USE    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_DISABLED  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_FAMILY = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_LOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BEGIN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_END    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DYN_ENABLE  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DYN_BEGIN   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_DYN_END     = 3'd7;

   typedef struct packed {
      logic [REQ_W-1:0]  req_type;
      logic              addr_family;
      logic [PFXH_W-1:0] addr_prefix_high;
      logic [POS_W-1:0]  addr_prefix_low;
      logic [POS_W-1:0]  addr_low;
   } ipa_req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    granted_low;
   } ipa_rsp_item_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_ADDR_CHECK,
      S_RMW,
      S_DYN_PREP,
      S_DYN_RANGE,
      S_SCAN_READ,
      S_SCAN_CHECK,
      S_GRANT
   } ipa_state_type;

endpackage

`default_nettype wire

### src/ip_address_pool_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Verify, invalid addresses, disabled dynamic and an inverted sub-range end in the first state
// after accept; static and reclaim add one map word read-modify-write, an empty clipped range adds
// the range state. A dynamic scan takes a read and a check state per map word on the one read port,
// up to MAP_WORDS + 1 words, and ends in a grant state on success; the result beat is registered.
// One request at a time, busy from accept to the result beat; the receiver cannot stall.
// After reset the map is cleared one word per cycle, all MAP_WORDS = 128 words, with busy high.
module ip_address_pool_allocator (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire ipa_pkg::ipa_req_item_type         req_data,
   output logic                                   rsp_valid,
   output ipa_pkg::ipa_rsp_item_type              rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [ipa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [ipa_pkg::CSR_W-1:0]         csr_data
);
   import ipa_pkg::*;

   ipa_state_type     state_ff, state_in;
   ipa_req_item_type  req_ff, req_in;
   ipa_rsp_item_type  rsp_data_ff, rsp_data_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              pool_family_ff, pool_family_in;
   logic [PFXH_W-1:0] prefix_high_ff, prefix_high_in;
   logic [POS_W-1:0]  prefix_low_ff, prefix_low_in;
   logic [POS_W-1:0]  pool_begin_ff, pool_begin_in;
   logic [POS_W-1:0]  pool_end_ff, pool_end_in;
   logic              dyn_enable_ff, dyn_enable_in;
   logic [POS_W-1:0]  dyn_begin_ff, dyn_begin_in;
   logic [POS_W-1:0]  dyn_end_ff, dyn_end_in;
   logic [POS_W-1:0]  cursor_ff, cursor_in;

   logic [OFF_W-1:0]  off_ff, off_in;
   logic [POS_W-1:0]  lo_ff, lo_in;
   logic [POS_W-1:0]  hi_ff, hi_in;
   logic [OFF_W-1:0]  scan_pos_ff, scan_pos_in;
   logic [OFF_W-1:0]  end_off_ff, end_off_in;
   logic [OFF_W-1:0]  lo_off_ff, lo_off_in;
   logic [OFF_W-1:0]  wrap_end_ff, wrap_end_in;
   logic              have_b_ff, have_b_in;
   logic              phase_b_ff, phase_b_in;
   logic [OFF_W-1:0]  grant_off_ff, grant_off_in;
   logic [WIDX_W-1:0] clear_addr_ff, clear_addr_in;

   // Map port
   logic              ram_wr_en;
   logic [WIDX_W-1:0] ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;
   logic [WIDX_W-1:0] ram_rd_addr;
   logic [WORD_W-1:0] ram_rd_data;

   // Result of the current state
   logic                done;
   logic [STATUS_W-1:0] done_status;
   logic [POS_W-1:0]    done_granted;

   logic accept;
   logic csr_write;
   logic clear_last;

   // Address check
   logic [POS_W-1:0]  pos_diff;
   logic              addr_ok;
   logic [OFF_W-1:0]  addr_off;
   logic              addr_finish;
   logic [WORD_W-1:0] off_mask;
   logic              off_taken;

   // Dynamic setup
   logic              dyn_bad;
   logic              dyn_stop;
   logic              cursor_out;
   logic [POS_W-1:0]  lo_calc;
   logic [POS_W-1:0]  hi_pool;
   logic [POS_W:0]    map_max;
   logic [POS_W-1:0]  hi_calc;
   logic              range_empty;
   logic [POS_W-1:0]  start_pos;
   logic [POS_W-1:0]  s_off_full;
   logic [POS_W-1:0]  lo_off_full;
   logic [POS_W-1:0]  hi_off_full;
   logic [OFF_W-1:0]  s_off;

   // Scan
   logic [WIDX_W-1:0] scan_word;
   logic [BIT_W-1:0]  scan_bit;
   logic              at_end;
   logic [BIT_W-1:0]  win_hi;
   logic              found;
   logic [BIT_W-1:0]  found_idx;
   logic              go_b;
   logic [POS_W-1:0]  grant_pos;

   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign clear_last = (clear_addr_ff == WIDX_W'(MAP_WORDS - 1));

   // Address membership
   assign pos_diff = req_ff.addr_low - pool_begin_ff;
   assign addr_ok  = (req_ff.addr_family == pool_family_ff)
                     && (!pool_family_ff
                         || (req_ff.addr_prefix_high == prefix_high_ff
                             && req_ff.addr_prefix_low == prefix_low_ff))
                     && (req_ff.addr_low >= pool_begin_ff)
                     && (req_ff.addr_low <= pool_end_ff)
                     && (pos_diff < POS_W'(POOL_ENTRIES));
   assign addr_off    = pos_diff[OFF_W-1:0];
   assign addr_finish = !addr_ok || (req_ff.req_type == REQ_VERIFY);
   assign off_mask    = WORD_W'(1) << off_ff[BIT_W-1:0];
   assign off_taken   = |(ram_rd_data & off_mask);

   // Dynamic sub-range bounds, clipped to the pool and the map
   assign dyn_bad    = (dyn_end_ff < dyn_begin_ff);
   assign dyn_stop   = !dyn_enable_ff || dyn_bad;
   assign cursor_out = (cursor_ff < dyn_begin_ff) || (cursor_ff > dyn_end_ff);
   assign lo_calc    = (dyn_begin_ff > pool_begin_ff) ? dyn_begin_ff : pool_begin_ff;
   assign hi_pool    = (dyn_end_ff < pool_end_ff) ? dyn_end_ff : pool_end_ff;
   assign map_max    = {1'b0, pool_begin_ff} + (POS_W + 1)'(POOL_ENTRIES - 1);
   assign hi_calc    = ({1'b0, hi_pool} > map_max) ? map_max[POS_W-1:0] : hi_pool;

   assign range_empty = (lo_ff > hi_ff);
   assign start_pos   = (cursor_ff > hi_ff) ? lo_ff :
                        ((cursor_ff > lo_ff) ? cursor_ff : lo_ff);
   assign s_off_full  = start_pos - pool_begin_ff;
   assign lo_off_full = lo_ff - pool_begin_ff;
   assign hi_off_full = hi_ff - pool_begin_ff;
   assign s_off       = s_off_full[OFF_W-1:0];

   assign scan_word = scan_pos_ff[OFF_W-1:BIT_W];
   assign scan_bit  = scan_pos_ff[BIT_W-1:0];
   assign at_end    = (scan_word == end_off_ff[OFF_W-1:BIT_W]);
   assign win_hi    = at_end ? end_off_ff[BIT_W-1:0] : '1;
   assign go_b      = !phase_b_ff && have_b_ff;
   assign grant_pos = pool_begin_ff + POS_W'(grant_off_ff);

   ipa_ffs u_ffs (
      .word   (ram_rd_data),
      .lo_bit (scan_bit),
      .hi_bit (win_hi),
      .found  (found),
      .index  (found_idx)
   );

   ipa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               state_in = (req_data.req_type == REQ_DYNAMIC) ? S_DYN_PREP : S_ADDR_CHECK;
            end
         end
         S_ADDR_CHECK: begin
            state_in = addr_finish ? S_IDLE : S_RMW;
         end
         S_RMW: begin
            state_in = S_IDLE;
         end
         S_DYN_PREP: begin
            state_in = dyn_stop ? S_IDLE : S_DYN_RANGE;
         end
         S_DYN_RANGE: begin
            state_in = range_empty ? S_IDLE : S_SCAN_READ;
         end
         S_SCAN_READ: begin
            state_in = S_SCAN_CHECK;
         end
         S_SCAN_CHECK: begin
            if (found) begin
               state_in = S_GRANT;
            end else if (at_end && !go_b) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_SCAN_READ;
            end
         end
         S_GRANT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Outputs: map port and result
   always_comb begin
      ram_wr_en    = 1'b0;
      ram_wr_addr  = clear_addr_ff;
      ram_wr_data  = '0;
      ram_rd_addr  = scan_word;
      done         = 1'b0;
      done_status  = STATUS_OK;
      done_granted = '0;
      case (state_ff)
         S_CLEAR: begin
            ram_wr_en = 1'b1;
         end
         S_ADDR_CHECK: begin
            ram_rd_addr = addr_off[OFF_W-1:BIT_W];
            if (!addr_ok) begin
               done        = 1'b1;
               done_status = STATUS_INVALID;
            end else if (req_ff.req_type == REQ_VERIFY) begin
               done = 1'b1;
            end
         end
         S_RMW: begin
            ram_wr_addr = off_ff[OFF_W-1:BIT_W];
            done        = 1'b1;
            if (req_ff.req_type == REQ_STATIC) begin
               if (off_taken) begin
                  done_status = STATUS_IN_USE;
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = ram_rd_data | off_mask;
               end
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_data = ram_rd_data & ~off_mask;
            end
         end
         S_DYN_PREP: begin
            if (!dyn_enable_ff) begin
               done        = 1'b1;
               done_status = STATUS_DISABLED;
            end else if (dyn_bad) begin
               done        = 1'b1;
               done_status = STATUS_EXHAUSTED;
            end
         end
         S_DYN_RANGE: begin
            if (range_empty) begin
               done        = 1'b1;
               done_status = STATUS_EXHAUSTED;
            end
         end
         S_SCAN_CHECK: begin
            if (found) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = scan_word;
               ram_wr_data = ram_rd_data | (WORD_W'(1) << found_idx);
            end else if (at_end && !go_b) begin
               done        = 1'b1;
               done_status = STATUS_EXHAUSTED;
            end
         end
         S_GRANT: begin
            done         = 1'b1;
            done_granted = grant_pos;
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      req_in         = accept ? req_data : req_ff;
      off_in         = off_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      scan_pos_in    = scan_pos_ff;
      end_off_in     = end_off_ff;
      lo_off_in      = lo_off_ff;
      wrap_end_in    = wrap_end_ff;
      have_b_in      = have_b_ff;
      phase_b_in     = phase_b_ff;
      grant_off_in   = grant_off_ff;
      clear_addr_in  = clear_addr_ff;
      cursor_in      = cursor_ff;
      pool_family_in = pool_family_ff;
      prefix_high_in = prefix_high_ff;
      prefix_low_in  = prefix_low_ff;
      pool_begin_in  = pool_begin_ff;
      pool_end_in    = pool_end_ff;
      dyn_enable_in  = dyn_enable_ff;
      dyn_begin_in   = dyn_begin_ff;
      dyn_end_in     = dyn_end_ff;

      case (state_ff)
         S_CLEAR: begin
            clear_addr_in = clear_addr_ff + WIDX_W'(1);
         end
         S_ADDR_CHECK: begin
            off_in = addr_off;
         end
         S_DYN_PREP: begin
            // Reload a stale cursor before the walk
            if (!dyn_stop && cursor_out) begin
               cursor_in = dyn_begin_ff;
            end
            lo_in = lo_calc;
            hi_in = hi_calc;
         end
         S_DYN_RANGE: begin
            scan_pos_in = s_off;
            end_off_in  = hi_off_full[OFF_W-1:0];
            lo_off_in   = lo_off_full[OFF_W-1:0];
            wrap_end_in = s_off - OFF_W'(1);
            have_b_in   = (s_off > lo_off_full[OFF_W-1:0]);
            phase_b_in  = 1'b0;
         end
         S_SCAN_CHECK: begin
            if (found) begin
               grant_off_in = {scan_word, found_idx};
            end else if (at_end) begin
               // Wrap to the start of the sub-range, stop short of the first position
               scan_pos_in = lo_off_ff;
               end_off_in  = wrap_end_ff;
               phase_b_in  = 1'b1;
            end else begin
               scan_pos_in = {scan_word + WIDX_W'(1), BIT_W'(0)};
            end
         end
         S_GRANT: begin
            cursor_in = (grant_pos == dyn_end_ff) ? dyn_begin_ff : grant_pos + POS_W'(1);
         end
         default: begin
            clear_addr_in = clear_addr_ff;
         end
      endcase

      if (csr_write) begin
         case (csr_index)
            CSR_POOL_FAMILY: pool_family_in = csr_data[0];
            CSR_PREFIX_HIGH: prefix_high_in = csr_data;
            CSR_PREFIX_LOW:  prefix_low_in  = csr_data[POS_W-1:0];
            CSR_POOL_BEGIN:  pool_begin_in  = csr_data[POS_W-1:0];
            CSR_POOL_END:    pool_end_in    = csr_data[POS_W-1:0];
            CSR_DYN_ENABLE:  dyn_enable_in  = csr_data[0];
            CSR_DYN_BEGIN: begin
               dyn_begin_in = csr_data[POS_W-1:0];
               cursor_in    = csr_data[POS_W-1:0];
            end
            CSR_DYN_END:     dyn_end_in     = csr_data[POS_W-1:0];
            default:         dyn_end_in     = dyn_end_ff;
         endcase
      end

      rsp_valid_in = done;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_data_in.status      = done_status;
         rsp_data_in.granted_low = done_granted;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clear_addr_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
         pool_family_ff <= 1'b0;
         prefix_high_ff <= '0;
         prefix_low_ff  <= '0;
         pool_begin_ff  <= '0;
         pool_end_ff    <= '0;
         dyn_enable_ff  <= 1'b0;
         dyn_begin_ff   <= '0;
         dyn_end_ff     <= '0;
         cursor_ff      <= '0;
      end else begin
         state_ff       <= state_in;
         clear_addr_ff  <= clear_addr_in;
         rsp_valid_ff   <= rsp_valid_in;
         pool_family_ff <= pool_family_in;
         prefix_high_ff <= prefix_high_in;
         prefix_low_ff  <= prefix_low_in;
         pool_begin_ff  <= pool_begin_in;
         pool_end_ff    <= pool_end_in;
         dyn_enable_ff  <= dyn_enable_in;
         dyn_begin_ff   <= dyn_begin_in;
         dyn_end_ff     <= dyn_end_in;
         cursor_ff      <= cursor_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rsp_data_ff  <= rsp_data_in;
      off_ff       <= off_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      scan_pos_ff  <= scan_pos_in;
      end_off_ff   <= end_off_in;
      lo_off_ff    <= lo_off_in;
      wrap_end_ff  <= wrap_end_in;
      have_b_ff    <= have_b_in;
      phase_b_ff   <= phase_b_in;
      grant_off_ff <= grant_off_in;
   end

endmodule

`default_nettype wire

### src/ipa_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ipa_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 128,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/ipa_ffs.sv
`timescale 1ns / 1ps
`default_nettype none

module ipa_ffs (
   input  wire logic [ipa_pkg::WORD_W-1:0] word,
   input  wire logic [ipa_pkg::BIT_W-1:0]  lo_bit,
   input  wire logic [ipa_pkg::BIT_W-1:0]  hi_bit,
   output logic                            found,
   output logic      [ipa_pkg::BIT_W-1:0]  index
);
   import ipa_pkg::*;

   logic [WORD_W-1:0] free_bits;

   // Free bits inside the window lo_bit..hi_bit
   always_comb begin
      for (int i = 0; i < WORD_W; i++) begin
         free_bits[i] = ~word[i] && (BIT_W'(i) >= lo_bit) && (BIT_W'(i) <= hi_bit);
      end
   end

   // Lowest free bit wins
   always_comb begin
      index = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            index = BIT_W'(i);
         end
      end
   end

   assign found = |free_bits;

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import ipa_pkg::*;

   localparam int          CYCLE_LIMIT  = 600_000;
   localparam int          DRAIN_CYCLES = 300;
   localparam int          PHASES       = 8;
   localparam int          PHASE_ITEMS  = 50;
   localparam logic [63:0] A64          = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [31:0] A32          = 32'hFFFF_FFFF;

   typedef struct {
      bit                    is_csr;
      logic [REQ_W-1:0]      kind;
      logic                  fam;
      logic [PFXH_W-1:0]     pfx_hi;
      logic [POS_W-1:0]      pfx_lo;
      logic [POS_W-1:0]      pos;
      bit                    typed;
      logic [STATUS_W-1:0]   want_status;
      logic [POS_W-1:0]      want_grant;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_W-1:0]      reg_val;
   } plan_row_type;

   localparam int PLAN_LEN = 47;

   // Reset state first, then an IPv6 pool at the top of the space, then edge pools.
   plan_row_type plan [PLAN_LEN] = '{
      '{0, REQ_STATIC,  0, 0, 0, 0,     1, STATUS_OK,        0, CSR_POOL_FAMILY, 0},
      '{0, REQ_STATIC,  0, 0, 0, 0,     1, STATUS_IN_USE,    0, CSR_POOL_FAMILY, 0},
      '{0, REQ_DYNAMIC, 0, 0, 0, 0,     1, STATUS_DISABLED,  0, CSR_POOL_FAMILY, 0},
      '{0, REQ_VERIFY,  1, 0, 0, 0,     1, STATUS_INVALID,   0, CSR_POOL_FAMILY, 0},
      '{0, REQ_VERIFY,  0, 0, 0, A32,   1, STATUS_INVALID,   0, CSR_POOL_FAMILY, 0},
      '{0, REQ_RECLAIM, 0, 0, 0, 0,     1, STATUS_OK,        0, CSR_POOL_FAMILY, 0},
      '{0, REQ_RECLAIM, 0, 0, 0, 0,     1, STATUS_OK,        0, CSR_POOL_FAMILY, 0},
      '{1, REQ_STATIC,  0, 0, 0, 0,     0, STATUS_OK,        0, CSR_POOL_FAMILY, 1},
      '{1, REQ_STATIC,  0, 0, 0, 0,     0, STATUS_OK,        0, CSR_PREFIX_HIGH, A64},
      '{1, REQ_STATIC,  0, 0, 0, 0,     0, STATUS_OK,        0, CSR_PREFIX_LOW,  A32},
      '{1, REQ_STATIC,  0, 0, 0, 0,     0, STATUS_OK,        0, CSR_POOL_BEGIN,  32'hFFFF_F000},
      '{1, REQ_STATIC,  0, 0, 0, 0,     0, STATUS_OK,        0, CSR_POOL_END,    A32},
      '{1, REQ_STATIC,  0, 0, 0, 0,     0, STATUS_OK,        0, CSR_DYN_ENABLE,  1},
      '{1, REQ_STATIC,  0, 0, 0, 0,     0, STATUS_OK,        0, CSR_DYN_BEGIN,   32'hFFFF_FFFE},
      '{1, REQ_STATIC,  0, 0, 0, 0,     0, STATUS_OK,        0, CSR_DYN_END,     A32},
      '{0, REQ_STATIC,  1, A64, A32, A32, 1, STATUS_OK,      0, CSR_POOL_FAMILY, 0},
      '{0, REQ_VERIFY,  1, 0,   A32, A32, 1, STATUS_INVALID, 0, CSR_POOL_FAMILY, 0},
      '{0, REQ_VERIFY,  1, A64, 0,   A32, 1, STATUS_INVALID, 0, CSR_POOL_FAMILY, 0},
      '{0, REQ_DYNAMIC, 0, 0, 0, 0,     1, STATUS_OK,  32'hFFFF_FFFE, CSR_POOL_FAMILY, 0},
      '{0, REQ_DYNAMIC, 0, 0, 0, 0,     1, STATUS_EXHAUSTED, 0, CSR_POOL_FAMILY, 0},
      '{0, REQ_RECLAIM, 1, A64, A32, A32, 1, STATUS_OK,      0, CSR_POOL_FAMILY, 0},
      '{0, REQ_DYNAMIC, 0, 0, 0, 0,     1, STATUS_OK,      A32, CSR_POOL_FAMILY, 0},
      '{0, REQ_VERIFY,  1, A64, A32, 32'hFFFF_F000, 1, STATUS_OK,      0, CSR_POOL_FAMILY, 0},
      '{0, REQ_VERIFY,  1, A64, A32, 32'hFFFF_EFFF, 1, STATUS_INVALID, 0, CSR_POOL_FAMILY, 0},
      '{1, REQ_STATIC,  0, 0, 0, 0,     0, STATUS_OK,        0, CSR_POOL_FAMILY, 0},
      '{1, REQ_STATIC,  0, 0, 0, 0,     0, STATUS_OK,        0, CSR_POOL_BEGIN,  0},
      '{1, REQ_STATIC,  0, 0, 0, 0,     0, STATUS_OK,        0, CSR_DYN_BEGIN,   10},
      '{1, REQ_STATIC,  0, 0, 0, 0,     0, STATUS_OK,        0, CSR_DYN_END,     5},
      '{0, REQ_VERIFY,  0, 0, 0, 4096,  1, STATUS_INVALID,   0, CSR_POOL_FAMILY, 0},
      '{0, REQ_DYNAMIC, 0, 0, 0, 0,     1, STATUS_EXHAUSTED, 0, CSR_POOL_FAMILY, 0},
      '{1, REQ_STATIC,  0, 0, 0, 0,     0, STATUS_OK,        0, CSR_POOL_BEGIN,  100},
      '{1, REQ_STATIC,  0, 0, 0, 0,     0, STATUS_OK,        0, CSR_POOL_END,    50},
      '{1, REQ_STATIC,  0, 0, 0, 0,     0, STATUS_OK,        0, CSR_DYN_BEGIN,   0},
      '{1, REQ_STATIC,  0, 0, 0, 0,     0, STATUS_OK,        0, CSR_DYN_END,     3},
      '{0, REQ_VERIFY,  0, 0, 0, 100,   1, STATUS_INVALID,   0, CSR_POOL_FAMILY, 0},
      '{0, REQ_DYNAMIC, 0, 0, 0, 0,     1, STATUS_EXHAUSTED, 0, CSR_POOL_FAMILY, 0},
      '{1, REQ_STATIC,  0, 0, 0, 0,     0, STATUS_OK,        0, CSR_POOL_BEGIN,  0},
      '{1, REQ_STATIC,  0, 0, 0, 0,     0, STATUS_OK,        0, CSR_POOL_END,    20},
      '{1, REQ_STATIC,  0, 0, 0, 0,     0, STATUS_OK,        0, CSR_DYN_BEGIN,   18},
      '{1, REQ_STATIC,  0, 0, 0, 0,     0, STATUS_OK,        0, CSR_DYN_END,     25},
      '{0, REQ_DYNAMIC, 0, 0, 0, 0,     0, STATUS_OK,        0, CSR_POOL_FAMILY, 0},
      '{0, REQ_DYNAMIC, 0, 0, 0, 0,     0, STATUS_OK,        0, CSR_POOL_FAMILY, 0},
      '{0, REQ_DYNAMIC, 0, 0, 0, 0,     0, STATUS_OK,        0, CSR_POOL_FAMILY, 0},
      '{0, REQ_DYNAMIC, 0, 0, 0, 0,     0, STATUS_OK,        0, CSR_POOL_FAMILY, 0},
      '{1, REQ_STATIC,  0, 0, 0, 0,     0, STATUS_OK,        0, CSR_DYN_END,     19},
      '{0, REQ_RECLAIM, 0, 0, 0, 18,    0, STATUS_OK,        0, CSR_POOL_FAMILY, 0},
      '{0, REQ_DYNAMIC, 0, 0, 0, 0,     0, STATUS_OK,        0, CSR_POOL_FAMILY, 0}
   };

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   ipa_req_item_type           req_data;
   logic                       rsp_valid;
   ipa_rsp_item_type           rsp_data;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_W-1:0]           csr_data;

   // Shadow of the pool registers and state
   logic                       cfg_family  = '0;
   logic [PFXH_W-1:0]          cfg_pfx_hi  = '0;
   logic [POS_W-1:0]           cfg_pfx_lo  = '0;
   logic [POS_W-1:0]           cfg_pool_lo = '0;
   logic [POS_W-1:0]           cfg_pool_hi = '0;
   logic                       cfg_dyn_en  = '0;
   logic [POS_W-1:0]           cfg_dyn_lo  = '0;
   logic [POS_W-1:0]           cfg_dyn_hi  = '0;
   logic [POS_W-1:0]           dyn_cursor  = '0;
   bit                         used_bits [POOL_ENTRIES];

   ipa_rsp_item_type           awaited_responses [$];
   ipa_rsp_item_type           oldest;
   ipa_req_item_type           cur_item;
   ipa_rsp_item_type           cur_want;
   int                         mismatches  = 0;
   int                         cycle_count = 0;
   int                         calm_left   = 0;

   ip_address_pool_allocator u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      case (idx)
         CSR_POOL_FAMILY: cfg_family  = val[0];
         CSR_PREFIX_HIGH: cfg_pfx_hi  = val;
         CSR_PREFIX_LOW:  cfg_pfx_lo  = val[POS_W-1:0];
         CSR_POOL_BEGIN:  cfg_pool_lo = val[POS_W-1:0];
         CSR_POOL_END:    cfg_pool_hi = val[POS_W-1:0];
         CSR_DYN_ENABLE:  cfg_dyn_en  = val[0];
         CSR_DYN_BEGIN: begin
            cfg_dyn_lo = val[POS_W-1:0];
            dyn_cursor = val[POS_W-1:0];
         end
         CSR_DYN_END:     cfg_dyn_hi  = val[POS_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic bit pool_offset(ipa_req_item_type it, output int off);
      off = 0;
      if (it.addr_family != cfg_family)
         return 0;
      if (cfg_family && (it.addr_prefix_high != cfg_pfx_hi || it.addr_prefix_low != cfg_pfx_lo))
         return 0;
      if (it.addr_low < cfg_pool_lo || it.addr_low > cfg_pool_hi)
         return 0;
      if (it.addr_low - cfg_pool_lo >= POOL_ENTRIES)
         return 0;
      off = int'(it.addr_low - cfg_pool_lo);
      return 1;
   endfunction

   // First free position in [from_pos, to_pos] clipped to [lo, hi]
   function automatic bit first_free(longint unsigned from_pos, longint unsigned to_pos,
                                     longint unsigned lo, longint unsigned hi,
                                     output longint unsigned found);
      longint unsigned p;
      longint unsigned base;
      found = 0;
      base  = 64'(cfg_pool_lo);
      if (from_pos < lo)
         from_pos = lo;
      if (to_pos > hi)
         to_pos = hi;
      for (p = from_pos; p <= to_pos; p++) begin
         if (!used_bits[p - base]) begin
            found = p;
            return 1;
         end
      end
      return 0;
   endfunction

   function automatic logic [STATUS_W-1:0] grant_dynamic(output logic [POS_W-1:0] grant);
      longint unsigned lo, hi, map_top, hit_pos, base, cur, dlo, dhi;
      bit              hit;
      grant   = '0;
      hit_pos = 0;
      base    = 64'(cfg_pool_lo);
      dlo     = 64'(cfg_dyn_lo);
      dhi     = 64'(cfg_dyn_hi);
      if (!cfg_dyn_en)
         return STATUS_DISABLED;
      if (dhi < dlo)
         return STATUS_EXHAUSTED;
      if (dyn_cursor < cfg_dyn_lo || dyn_cursor > cfg_dyn_hi)
         dyn_cursor = cfg_dyn_lo;
      cur     = 64'(dyn_cursor);
      lo      = (dlo > base) ? dlo : base;
      hi      = (cfg_dyn_hi < cfg_pool_hi) ? dhi : 64'(cfg_pool_hi);
      map_top = base + 64'(POOL_ENTRIES) - 64'd1;
      if (hi > map_top)
         hi = map_top;
      if (lo > hi)
         return STATUS_EXHAUSTED;
      hit = first_free(cur, dhi, lo, hi, hit_pos);
      if (!hit && cur > dlo)
         hit = first_free(dlo, cur - 1, lo, hi, hit_pos);
      if (!hit)
         return STATUS_EXHAUSTED;
      used_bits[hit_pos - base] = 1'b1;
      dyn_cursor = (hit_pos == dhi) ? cfg_dyn_lo : hit_pos[POS_W-1:0] + 1;
      grant = hit_pos[POS_W-1:0];
      return STATUS_OK;
   endfunction

   function automatic ipa_rsp_item_type pool_response(ipa_req_item_type it);
      ipa_rsp_item_type res;
      logic [POS_W-1:0] grant;
      int               off;
      res = '0;
      if (it.req_type == REQ_DYNAMIC) begin
         res.status      = grant_dynamic(grant);
         res.granted_low = grant;
      end else if (!pool_offset(it, off)) begin
         res.status = STATUS_INVALID;
      end else begin
         case (it.req_type)
            REQ_STATIC: begin
               if (used_bits[off]) begin
                  res.status = STATUS_IN_USE;
               end else begin
                  used_bits[off] = 1'b1;
                  res.status     = STATUS_OK;
               end
            end
            REQ_RECLAIM: begin
               used_bits[off] = 1'b0;
               res.status     = STATUS_OK;
            end
            default: res.status = STATUS_OK;
         endcase
      end
      return res;
   endfunction

   // Mostly well-formed requests aimed at the current pool, some noise
   function automatic ipa_req_item_type make_item();
      ipa_req_item_type it;
      int unsigned      pick;
      int unsigned      span;
      it.addr_prefix_high = {$urandom, $urandom};
      it.addr_prefix_low  = $urandom;
      it.addr_low         = $urandom;
      it.addr_family      = 1'($urandom_range(0, 1));
      it.req_type         = REQ_W'($urandom_range(0, 3));
      if ($urandom_range(0, 99) < 8)
         return it;
      pick = $urandom_range(0, 99);
      if (pick < 35)
         it.req_type = REQ_STATIC;
      else if (pick < 60)
         it.req_type = REQ_DYNAMIC;
      else if (pick < 80)
         it.req_type = REQ_RECLAIM;
      else
         it.req_type = REQ_VERIFY;
      if ($urandom_range(0, 19) != 0)
         it.addr_family = cfg_family;
      if ($urandom_range(0, 19) != 0) begin
         it.addr_prefix_high = cfg_pfx_hi;
         it.addr_prefix_low  = cfg_pfx_lo;
      end
      if (cfg_pool_hi >= cfg_pool_lo && cfg_pool_hi - cfg_pool_lo < 4200)
         span = cfg_pool_hi - cfg_pool_lo;
      else
         span = 40;
      it.addr_low = cfg_pool_lo - 1 + $urandom_range(0, span + 2);
      return it;
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      apply_csr(idx, val);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      do
         @(posedge clock);
      while (awaited_responses.size() != 0 || busy);
   endtask

   task automatic issue_req(ipa_req_item_type it, bit typed, ipa_rsp_item_type typed_rsp);
      int               gap;
      ipa_rsp_item_type pred;
      if (calm_left > 0) begin
         calm_left--;
         gap = 0;
      end else begin
         gap = $urandom_range(0, 6);
         if ($urandom_range(0, 15) == 0)
            calm_left = $urandom_range(5, 25);
      end
      // busy is high on the edge after an accept, so this edge costs nothing
      @(posedge clock);
      repeat (gap) @(posedge clock);
      start    <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      pred = pool_response(it);
      awaited_responses.push_back(typed ? typed_rsp : pred);
      start <= 1'b0;
   endtask

   task automatic reshape_pool();
      logic [POS_W-1:0] lo, hi, dlo, dhi;
      int unsigned      span;
      span = $urandom_range(0, 40);
      case ($urandom_range(0, 5))
         0:       lo = '0;
         1:       lo = A32 - $urandom_range(0, 40);
         default: lo = $urandom;
      endcase
      hi = lo + span;
      if ($urandom_range(0, 7) == 0)
         hi = lo + 4200;
      if (hi < lo)
         hi = A32;
      if ($urandom_range(0, 9) == 0)
         hi = lo - $urandom_range(1, 3);
      dlo = lo + $urandom_range(0, 8) - 3;
      dhi = dlo + $urandom_range(0, 30);
      if ($urandom_range(0, 15) == 0)
         dhi = dlo - 1;
      // skip some writes so the cursor can be left outside the new range
      if ($urandom_range(0, 7) != 0) write_reg(CSR_POOL_FAMILY, CSR_W'($urandom_range(0, 1)));
      if ($urandom_range(0, 7) != 0) write_reg(CSR_PREFIX_HIGH, {$urandom, $urandom});
      if ($urandom_range(0, 7) != 0) write_reg(CSR_PREFIX_LOW, CSR_W'($urandom));
      if ($urandom_range(0, 7) != 0) write_reg(CSR_POOL_BEGIN, CSR_W'(lo));
      if ($urandom_range(0, 7) != 0) write_reg(CSR_POOL_END, CSR_W'(hi));
      if ($urandom_range(0, 7) != 0) write_reg(CSR_DYN_ENABLE, CSR_W'($urandom_range(0, 9) != 0));
      if ($urandom_range(0, 7) != 0) write_reg(CSR_DYN_BEGIN, CSR_W'(dlo));
      if ($urandom_range(0, 7) != 0) write_reg(CSR_DYN_END, CSR_W'(dhi));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (awaited_responses.size() == 0) begin
            $display("%0t: unexpected result beat, status %0d granted %h",
                     $time, rsp_data.status, rsp_data.granted_low);
            mismatches++;
         end else begin
            oldest = awaited_responses.pop_front();
            if (rsp_data.status !== oldest.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, oldest.status, rsp_data.status);
               mismatches++;
            end
            if (rsp_data.granted_low !== oldest.granted_low) begin
               $display("%0t: granted_low expected %h actual %h",
                        $time, oldest.granted_low, rsp_data.granted_low);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ip_address_pool_allocator regression: fail");
         $finish;
      end
   end

   initial begin
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            wait_idle();
            write_reg(plan[i].reg_idx, plan[i].reg_val);
         end else begin
            cur_item.req_type         = plan[i].kind;
            cur_item.addr_family      = plan[i].fam;
            cur_item.addr_prefix_high = plan[i].pfx_hi;
            cur_item.addr_prefix_low  = plan[i].pfx_lo;
            cur_item.addr_low         = plan[i].pos;
            cur_want.status           = plan[i].want_status;
            cur_want.granted_low      = plan[i].want_grant;
            issue_req(cur_item, plan[i].typed, cur_want);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         reshape_pool();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 30) == 0)
               wait_idle();
            issue_req(make_item(), 1'b0, '0);
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && awaited_responses.size() == 0)
         $display("ip_address_pool_allocator regression: pass");
      else
         $display("ip_address_pool_allocator regression: fail");
      $finish;
   end

endmodule
